@@ rtl/met_pkg.sv @@
// met_pkg: shared types and constants for the motor encoder feedback tracker
// no dependencies
package met_pkg;

  localparam int ANGLE_W = 16;
  localparam int WORD_W  = 16;
  localparam int TEMP_W  = 8;
  localparam int ID_W    = 11;
  localparam int CNT_W   = 8;
  localparam int REV_W   = 19;
  localparam int TOTAL_W = 33;
  localparam int OSLOT_W = 3;
  localparam int CFG_W   = 11;
  localparam int CAL_W   = 8;
  localparam int MUL_W   = 40;

  localparam logic [CNT_W-1:0]        CNT_MAX       = 8'd255;
  localparam logic signed [REV_W-1:0] REV_MAX       = 19'sd262143;
  localparam logic signed [REV_W-1:0] REV_MIN       = -19'sd262144;
  localparam logic [ID_W-1:0]         BASE_ID_RST   = 11'd513;
  localparam logic [CAL_W-1:0]        CAL_LIMIT_RST = 8'd50;

  typedef enum logic [0:0] {
    REG_BASE_ID   = 1'b0,
    REG_CAL_LIMIT = 1'b1
  } reg_idx_t;

  // per-slot values after the update of one word
  typedef struct packed {
    logic                      calib;
    logic [ANGLE_W-1:0]        angle;
    logic [ANGLE_W-1:0]        offset;
    logic signed [REV_W-1:0]   rev;
  } slot_upd_t;

endpackage

@@ rtl/met_decode.sv @@
// met_decode: bus and identifier match, slot index from identifier
// depends on met_pkg
module met_decode #(
  parameter int MOTOR_COUNT = 7,
  parameter int SLOT_W      = 3
) (
  input  logic                        bus_index,
  input  logic [met_pkg::ID_W-1:0]    frame_identifier,
  input  logic [met_pkg::ID_W-1:0]    base_identifier,
  output logic                        hit,
  output logic [SLOT_W-1:0]           slot
);

  logic [met_pkg::ID_W:0] diff;

  assign diff = {1'b0, frame_identifier} - {1'b0, base_identifier};
  assign hit  = !bus_index && !diff[met_pkg::ID_W]
                && (diff < (met_pkg::ID_W+1)'(MOTOR_COUNT));
  assign slot = diff[SLOT_W-1:0];

endmodule

@@ rtl/met_track.sv @@
// met_track: per-slot frame count, angle, offset and turn count
// depends on met_pkg
module met_track #(
  parameter int MOTOR_COUNT     = 7,
  parameter int COUNTS_PER_TURN = 8192,
  parameter int SLOT_W          = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd_en,
  input  logic [SLOT_W-1:0]             slot,
  input  logic [met_pkg::ANGLE_W-1:0]   angle_in,
  input  logic [met_pkg::CAL_W-1:0]     calibration_limit,
  output met_pkg::slot_upd_t            upd
);

  localparam logic signed [17:0] HALF = 18'(COUNTS_PER_TURN / 2);

  logic [met_pkg::CNT_W-1:0]          cnt_r    [MOTOR_COUNT];
  logic [met_pkg::ANGLE_W-1:0]        angle_r  [MOTOR_COUNT];
  logic [met_pkg::ANGLE_W-1:0]        offset_r [MOTOR_COUNT];
  logic signed [met_pkg::REV_W-1:0]   rev_r    [MOTOR_COUNT];

  logic [met_pkg::CNT_W-1:0]          cnt;
  logic [met_pkg::CNT_W-1:0]          cnt_nxt;
  logic signed [met_pkg::REV_W-1:0]   rev;
  logic signed [met_pkg::REV_W-1:0]   rev_nxt;
  logic signed [17:0]                 delta;
  logic                               calib;

  always_comb begin
    cnt     = cnt_r[slot];
    rev     = rev_r[slot];
    calib   = cnt <= calibration_limit;
    cnt_nxt = (cnt == met_pkg::CNT_MAX) ? cnt : cnt + 1'b1;
    delta   = $signed({2'b00, angle_in}) - $signed({2'b00, angle_r[slot]});
    rev_nxt = rev;
    if (!calib) begin
      if (delta > HALF) begin
        if (rev > met_pkg::REV_MIN) rev_nxt = rev - 1'b1;
      end else if (delta < -HALF) begin
        if (rev < met_pkg::REV_MAX) rev_nxt = rev + 1'b1;
      end
    end
    upd.calib  = calib;
    upd.angle  = angle_in;
    upd.offset = calib ? angle_in : offset_r[slot];
    upd.rev    = rev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        cnt_r[k]    <= '0;
        angle_r[k]  <= '0;
        offset_r[k] <= '0;
        rev_r[k]    <= '0;
      end
    end else if (upd_en) begin
      cnt_r[slot]    <= cnt_nxt;
      angle_r[slot]  <= upd.angle;
      offset_r[slot] <= upd.offset;
      rev_r[slot]    <= upd.rev;
    end
  end

endmodule

@@ rtl/motor_encoder_feedback_tracker.sv @@
// motor_encoder_feedback_tracker: top level, input register, result register
// depends on met_pkg, met_decode, met_track
//
//  channel | ports                          | moves
//  in      | in_valid / in_ready            | one feedback frame word
//  out     | out_valid / out_ready          | one slot update word
//  cfg     | cfg_we, cfg_index, cfg_data    | register write, no wait
//
// a word passes the input register, then the result register; one word per cycle sustained while out_ready holds
// the slot state read-modify-write, read combinationally and written at the clock edge, sets the rate
// second-bus and unknown-identifier words are dropped without a result
// reset clears all slot state and loads register defaults
// a stalled result holds while the next word waits in the input register
module motor_encoder_feedback_tracker #(
  parameter int MOTOR_COUNT     = 7,
  parameter int COUNTS_PER_TURN = 8192
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_index,
  input  logic [met_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_bus_index,
  input  logic [met_pkg::ID_W-1:0]              in_frame_identifier,
  input  logic [met_pkg::ANGLE_W-1:0]           in_angle_word,
  input  logic signed [met_pkg::WORD_W-1:0]     in_speed_word,
  input  logic signed [met_pkg::WORD_W-1:0]     in_current_word,
  input  logic [met_pkg::TEMP_W-1:0]            in_temperature_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [met_pkg::OSLOT_W-1:0]           out_motor_slot,
  output logic                                  out_calibrating,
  output logic [met_pkg::ANGLE_W-1:0]           out_angle_now,
  output logic signed [met_pkg::WORD_W-1:0]     out_speed_rpm,
  output logic signed [met_pkg::WORD_W-1:0]     out_current_value,
  output logic [met_pkg::TEMP_W-1:0]            out_temperature,
  output logic signed [met_pkg::REV_W-1:0]      out_turn_count,
  output logic signed [met_pkg::TOTAL_W-1:0]    out_total_angle
);

  localparam int SLOT_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic signed [met_pkg::MUL_W-1:0] CPT = met_pkg::MUL_W'(COUNTS_PER_TURN);

  logic [met_pkg::ID_W-1:0]   base_id_r;
  logic [met_pkg::CAL_W-1:0]  cal_limit_r;

  logic                                s1_valid_r;
  logic                                s1_bus_r;
  logic [met_pkg::ID_W-1:0]            s1_ident_r;
  logic [met_pkg::ANGLE_W-1:0]         s1_angle_r;
  logic signed [met_pkg::WORD_W-1:0]   s1_speed_r;
  logic signed [met_pkg::WORD_W-1:0]   s1_current_r;
  logic [met_pkg::TEMP_W-1:0]          s1_temp_r;

  logic                                out_valid_r;
  logic [met_pkg::OSLOT_W-1:0]         out_slot_r;
  logic                                out_calib_r;
  logic [met_pkg::ANGLE_W-1:0]         out_angle_r;
  logic [met_pkg::ANGLE_W-1:0]         out_offset_r;
  logic signed [met_pkg::WORD_W-1:0]   out_speed_r;
  logic signed [met_pkg::WORD_W-1:0]   out_current_r;
  logic [met_pkg::TEMP_W-1:0]          out_temp_r;
  logic signed [met_pkg::REV_W-1:0]    out_rev_r;

  logic                                hit;
  logic [SLOT_W-1:0]                   slot;
  logic [3:0]                          slot_wide;
  logic                                s1_adv;
  logic                                upd_en;
  met_pkg::slot_upd_t                  upd;
  logic signed [met_pkg::MUL_W-1:0]    total;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r   <= met_pkg::BASE_ID_RST;
      cal_limit_r <= met_pkg::CAL_LIMIT_RST;
    end else if (cfg_we) begin
      case (met_pkg::reg_idx_t'(cfg_index))
        met_pkg::REG_BASE_ID:   base_id_r   <= cfg_data;
        met_pkg::REG_CAL_LIMIT: cal_limit_r <= cfg_data[met_pkg::CAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !s1_valid_r || s1_adv;
  assign s1_adv   = s1_valid_r && (!hit || !out_valid_r || out_ready);
  assign upd_en   = s1_adv && hit;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_bus_r     <= in_bus_index;
      s1_ident_r   <= in_frame_identifier;
      s1_angle_r   <= in_angle_word;
      s1_speed_r   <= in_speed_word;
      s1_current_r <= in_current_word;
      s1_temp_r    <= in_temperature_byte;
    end
  end

  met_decode #(
    .MOTOR_COUNT(MOTOR_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_decode (
    .bus_index       (s1_bus_r),
    .frame_identifier(s1_ident_r),
    .base_identifier (base_id_r),
    .hit             (hit),
    .slot            (slot)
  );

  met_track #(
    .MOTOR_COUNT    (MOTOR_COUNT),
    .COUNTS_PER_TURN(COUNTS_PER_TURN),
    .SLOT_W         (SLOT_W)
  ) u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .upd_en           (upd_en),
    .slot             (slot),
    .angle_in         (s1_angle_r),
    .calibration_limit(cal_limit_r),
    .upd              (upd)
  );

  assign slot_wide = 4'(slot);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      out_slot_r    <= slot_wide[met_pkg::OSLOT_W-1:0];
      out_calib_r   <= upd.calib;
      out_angle_r   <= upd.angle;
      out_offset_r  <= upd.offset;
      out_rev_r     <= upd.rev;
      out_speed_r   <= upd.calib ? '0 : s1_speed_r;
      out_current_r <= upd.calib ? '0 : s1_current_r;
      out_temp_r    <= upd.calib ? '0 : s1_temp_r;
    end
  end

  // unwrapped angle from the registered turn count
  assign total = met_pkg::MUL_W'(out_rev_r) * CPT
               + $signed({24'd0, out_angle_r})
               - $signed({24'd0, out_offset_r});

  assign out_valid         = out_valid_r;
  assign out_motor_slot    = out_slot_r;
  assign out_calibrating   = out_calib_r;
  assign out_angle_now     = out_angle_r;
  assign out_speed_rpm     = out_speed_r;
  assign out_current_value = out_current_r;
  assign out_temperature   = out_temp_r;
  assign out_turn_count    = out_rev_r;
  assign out_total_angle   = total[met_pkg::TOTAL_W-1:0];

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |=> out_valid_r)
    else $error("slot update not presented as result");

  a_drop_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !hit) |-> s1_adv)
    else $error("dropped frame stalled the input register");

  a_calib_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_calib_r) |->
      (out_speed_r == '0 && out_current_r == '0 && out_temp_r == '0
       && out_offset_r == out_angle_r))
    else $error("calibrating result carries data or offset mismatch");

  a_no_load_over_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !upd_en)
    else $error("result overwritten while stalled");

endmodule

@@ test/tb_motor_encoder_feedback_tracker.sv @@
// tb_motor_encoder_feedback_tracker: self-checking bench for the encoder feedback tracker
// predicts slot state and turn unwrap per frame word, checks every result word in order
// depends on met_pkg and the motor_encoder_feedback_tracker rtl
module tb_motor_encoder_feedback_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOTOR_COUNT     = 7;
  localparam int COUNTS_PER_TURN = 8192;
  localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

  typedef struct packed {
    logic                                bus;
    logic [met_pkg::ID_W-1:0]            ident;
    logic [met_pkg::ANGLE_W-1:0]         angle;
    logic signed [met_pkg::WORD_W-1:0]   speed;
    logic signed [met_pkg::WORD_W-1:0]   current;
    logic [met_pkg::TEMP_W-1:0]          temp;
  } frame_t;

  typedef struct packed {
    logic [met_pkg::OSLOT_W-1:0]         slot;
    logic                                calib;
    logic [met_pkg::ANGLE_W-1:0]         angle;
    logic signed [met_pkg::WORD_W-1:0]   speed;
    logic signed [met_pkg::WORD_W-1:0]   current;
    logic [met_pkg::TEMP_W-1:0]          temp;
    logic signed [met_pkg::REV_W-1:0]    turns;
    logic signed [met_pkg::TOTAL_W-1:0]  total;
  } slot_word_t;

  class feedback_scoreboard;
    logic [met_pkg::ID_W-1:0]          base_id;
    logic [met_pkg::CAL_W-1:0]         cal_limit;
    logic [met_pkg::CNT_W-1:0]         frame_cnt[MOTOR_COUNT];
    logic [met_pkg::ANGLE_W-1:0]       last_pos[MOTOR_COUNT];
    logic [met_pkg::ANGLE_W-1:0]       zero_pos[MOTOR_COUNT];
    logic signed [met_pkg::REV_W-1:0]  turns[MOTOR_COUNT];
    slot_word_t                        pending_updates[$];
    int                                bad_words;

    function new();
      base_id = met_pkg::BASE_ID_RST;
      cal_limit = met_pkg::CAL_LIMIT_RST;
      bad_words = 0;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        frame_cnt[k] = '0;
        last_pos[k] = '0;
        zero_pos[k] = '0;
        turns[k] = '0;
      end
    endfunction

    function void set_reg(met_pkg::reg_idx_t idx, int unsigned value);
      if (idx == met_pkg::REG_BASE_ID) base_id = value[met_pkg::ID_W-1:0];
      else cal_limit = value[met_pkg::CAL_W-1:0];
    endfunction

    function int pending();
      return pending_updates.size();
    endfunction

    function void unwrap_frame(frame_t f);
      int         slot;
      int         delta;
      logic       calib;
      longint     total;
      slot_word_t w;
      if (f.bus) return;
      if (f.ident < base_id) return;
      slot = int'(f.ident) - int'(base_id);
      if (slot >= MOTOR_COUNT) return;
      calib = frame_cnt[slot] <= cal_limit;
      if (frame_cnt[slot] != met_pkg::CNT_MAX) frame_cnt[slot]++;
      if (calib) begin
        last_pos[slot] = f.angle;
        zero_pos[slot] = f.angle;
      end else begin
        delta = int'(f.angle) - int'(last_pos[slot]);
        last_pos[slot] = f.angle;
        if (delta > HALF_TURN) begin
          if (turns[slot] > met_pkg::REV_MIN) turns[slot]--;
        end else if (delta < -HALF_TURN) begin
          if (turns[slot] < met_pkg::REV_MAX) turns[slot]++;
        end
      end
      total = longint'(turns[slot]) * COUNTS_PER_TURN + longint'(last_pos[slot])
            - longint'(zero_pos[slot]);
      w.slot    = slot[met_pkg::OSLOT_W-1:0];
      w.calib   = calib;
      w.angle   = last_pos[slot];
      w.speed   = calib ? '0 : f.speed;
      w.current = calib ? '0 : f.current;
      w.temp    = calib ? '0 : f.temp;
      w.turns   = turns[slot];
      w.total   = total[met_pkg::TOTAL_W-1:0];
      pending_updates.push_back(w);
    endfunction

    function void check_word(slot_word_t got);
      slot_word_t want;
      if (pending_updates.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("%0t word error: unexpected result word %p", $realtime, got);
        return;
      end
      want = pending_updates.pop_front();
      if (got.slot !== want.slot || got.calib !== want.calib || got.angle !== want.angle ||
          got.speed !== want.speed || got.current !== want.current ||
          got.temp !== want.temp || got.turns !== want.turns || got.total !== want.total) begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("%0t word error: slot %0d/%0d calib %0d/%0d angle %0d/%0d speed %0d/%0d",
                   $realtime, want.slot, got.slot, want.calib, got.calib, want.angle,
                   got.angle, want.speed, got.speed);
          $display("  current %0d/%0d temp %0d/%0d turns %0d/%0d total %0d/%0d (exp/act)",
                   want.current, got.current, want.temp, got.temp, want.turns, got.turns,
                   want.total, got.total);
        end
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [0:0]                         cfg_index;
  logic [met_pkg::CFG_W-1:0]          cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic                               in_bus_index;
  logic [met_pkg::ID_W-1:0]           in_frame_identifier;
  logic [met_pkg::ANGLE_W-1:0]        in_angle_word;
  logic signed [met_pkg::WORD_W-1:0]  in_speed_word;
  logic signed [met_pkg::WORD_W-1:0]  in_current_word;
  logic [met_pkg::TEMP_W-1:0]         in_temperature_byte;
  logic                               out_valid;
  logic                               out_ready;
  logic [met_pkg::OSLOT_W-1:0]        out_motor_slot;
  logic                               out_calibrating;
  logic [met_pkg::ANGLE_W-1:0]        out_angle_now;
  logic signed [met_pkg::WORD_W-1:0]  out_speed_rpm;
  logic signed [met_pkg::WORD_W-1:0]  out_current_value;
  logic [met_pkg::TEMP_W-1:0]         out_temperature;
  logic signed [met_pkg::REV_W-1:0]   out_turn_count;
  logic signed [met_pkg::TOTAL_W-1:0] out_total_angle;

  feedback_scoreboard          sb = new();
  bit                          idle_on;
  logic [met_pkg::ID_W-1:0]    cur_base;
  int                          drive_pos[MOTOR_COUNT];
  int                          stall_left;

  motor_encoder_feedback_tracker #(
    .MOTOR_COUNT     (MOTOR_COUNT),
    .COUNTS_PER_TURN (COUNTS_PER_TURN)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_bus_index        (in_bus_index),
    .in_frame_identifier (in_frame_identifier),
    .in_angle_word       (in_angle_word),
    .in_speed_word       (in_speed_word),
    .in_current_word     (in_current_word),
    .in_temperature_byte (in_temperature_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motor_slot      (out_motor_slot),
    .out_calibrating     (out_calibrating),
    .out_angle_now       (out_angle_now),
    .out_speed_rpm       (out_speed_rpm),
    .out_current_value   (out_current_value),
    .out_temperature     (out_temperature),
    .out_turn_count      (out_turn_count),
    .out_total_angle     (out_total_angle)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 3);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word('{out_motor_slot, out_calibrating, out_angle_now, out_speed_rpm,
                      out_current_value, out_temperature, out_turn_count,
                      out_total_angle});
  end

  function automatic frame_t mk_frame(logic bus, int ident, int angle, int speed, int current,
                                      int temp);
    frame_t f;
    f.bus     = bus;
    f.ident   = ident[met_pkg::ID_W-1:0];
    f.angle   = angle[met_pkg::ANGLE_W-1:0];
    f.speed   = speed[met_pkg::WORD_W-1:0];
    f.current = current[met_pkg::WORD_W-1:0];
    f.temp    = temp[met_pkg::TEMP_W-1:0];
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int     slot;
    int     pick;
    int     last;
    pick      = $urandom_range(0, 99);
    f.bus     = 1'b0;
    f.ident   = met_pkg::ID_W'($urandom);
    f.angle   = met_pkg::ANGLE_W'($urandom);
    f.speed   = met_pkg::WORD_W'($urandom);
    f.current = met_pkg::WORD_W'($urandom);
    f.temp    = met_pkg::TEMP_W'($urandom);
    if (pick < 8) begin
      f.bus = 1'b1;
    end else if (pick >= 16) begin
      slot = $urandom_range(0, 1) ? 0 : $urandom_range(0, MOTOR_COUNT - 1);
      f.ident = met_pkg::ID_W'(int'(cur_base) + slot);
      last = drive_pos[slot];
      case ($urandom_range(0, 9))
        0: ;
        1: f.angle = met_pkg::ANGLE_W'(last + 4095 + int'($urandom_range(0, 3)));
        2: f.angle = met_pkg::ANGLE_W'(last - 4095 - int'($urandom_range(0, 3)));
        default: f.angle = met_pkg::ANGLE_W'((last + int'($urandom_range(0, 800))
                                              + COUNTS_PER_TURN - 400) % COUNTS_PER_TURN);
      endcase
      drive_pos[slot] = int'(f.angle);
    end
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_bus_index        = f.bus;
    in_frame_identifier = f.ident;
    in_angle_word       = f.angle;
    in_speed_word       = f.speed;
    in_current_word     = f.current;
    in_temperature_byte = f.temp;
    in_valid            = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.unwrap_frame(f);
  endtask

  task automatic end_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(met_pkg::reg_idx_t idx, int unsigned value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value[met_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic reconfigure(int unsigned base, int unsigned limit);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(met_pkg::REG_BASE_ID, base);
    write_reg(met_pkg::REG_CAL_LIMIT, limit);
    cur_base = base[met_pkg::ID_W-1:0];
  endtask

  task automatic run_random(int n, bit idle);
    idle_on = idle;
    repeat (n) send_frame(random_frame());
    end_input();
  endtask

  initial begin
    #2_000_000;
    $display("motor_encoder_feedback_tracker: mismatch");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = met_pkg::REG_BASE_ID;
    cfg_data            = '0;
    in_valid            = 1'b0;
    in_bus_index        = 1'b0;
    in_frame_identifier = '0;
    in_angle_word       = '0;
    in_speed_word       = '0;
    in_current_word     = '0;
    in_temperature_byte = '0;
    idle_on             = 1'b0;
    cur_base            = met_pkg::BASE_ID_RST;
    for (int k = 0; k < MOTOR_COUNT; k++) drive_pos[k] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // default registers: dropped words and calibration captures
    send_frame(mk_frame(1'b1, 513, 100, 1, 2, 3));
    send_frame(mk_frame(1'b0, 512, 100, 1, 2, 3));
    send_frame(mk_frame(1'b0, 520, 100, 1, 2, 3));
    send_frame(mk_frame(1'b0, 2047, 100, 1, 2, 3));
    send_frame(mk_frame(1'b0, 0, 100, 1, 2, 3));
    send_frame(mk_frame(1'b0, 513, 0, -32768, 32767, 255));
    send_frame(mk_frame(1'b0, 519, 65535, 32767, -32768, 0));
    send_frame(mk_frame(1'b0, 516, 8191, -1, 1, 128));
    end_input();

    // lowest base, calibration limit zero so only the first word per slot calibrates: wrap thresholds on slot 1
    reconfigure(0, 0);
    send_frame(mk_frame(1'b0, 1, 100, 10, 20, 30));
    send_frame(mk_frame(1'b0, 1, 4196, 11, 21, 31));
    send_frame(mk_frame(1'b0, 1, 100, 12, 22, 32));
    send_frame(mk_frame(1'b0, 1, 4197, 13, 23, 33));
    send_frame(mk_frame(1'b0, 1, 100, 14, 24, 34));
    send_frame(mk_frame(1'b0, 1, 8191, 15, 25, 35));
    send_frame(mk_frame(1'b0, 1, 0, 16, 26, 36));
    send_frame(mk_frame(1'b0, 1, 65535, -32768, -32768, 255));
    send_frame(mk_frame(1'b0, 1, 0, 32767, 32767, 0));
    send_frame(mk_frame(1'b0, 7, 50, 1, 1, 1));
    send_frame(mk_frame(1'b0, 6, 4000, -5, -6, 7));
    end_input();

    run_random(200, 1'b1);
    reconfigure(2047, 255);
    run_random(200, 1'b1);
    reconfigure(1000, 3);
    run_random(200, 1'b1);
    reconfigure(1, 17);
    run_random(250, 1'b0);

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.bad_words == 0)
      $display("motor_encoder_feedback_tracker: match");
    else
      $display("motor_encoder_feedback_tracker: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/met_pkg.sv
rtl/met_decode.sv
rtl/met_track.sv
rtl/motor_encoder_feedback_tracker.sv
test/tb_motor_encoder_feedback_tracker.sv
